[src/psg_pkg.sv]
// Package for the three-voice sound core: bus action codes, register map
// constants and the Q0.15 volume table. No dependencies.
package psg_pkg;

  typedef enum logic [1:0] {
    ACT_LATCH = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_TICK  = 2'd3
  } action_e;

  localparam int unsigned NUM_REGS  = 16;
  localparam int unsigned MIX_W     = 18;
  localparam int unsigned AMP_W     = 16;

  localparam logic [3:0] REG_NOISE_PER  = 4'd6;
  localparam logic [3:0] REG_MIXER      = 4'd7;
  localparam logic [3:0] REG_AMP_BASE   = 4'd8;
  localparam logic [3:0] REG_ENV_FINE   = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;
  localparam logic [3:0] REG_PORT_A     = 4'd14;
  localparam logic [3:0] REG_PORT_B     = 4'd15;

  // Logarithmic volume steps, table value times 32767, rounded
  function automatic logic [AMP_W-1:0] vol_q15(input logic [3:0] idx);
    logic [AMP_W-1:0] amp;
    case (idx)
      4'd0:    amp = 16'd0;
      4'd1:    amp = 16'd449;
      4'd2:    amp = 16'd672;
      4'd3:    amp = 16'd1006;
      4'd4:    amp = 16'd1491;
      4'd5:    amp = 16'd2238;
      4'd6:    amp = 16'd3342;
      4'd7:    amp = 16'd5007;
      4'd8:    amp = 16'd7337;
      4'd9:    amp = 16'd10682;
      4'd10:   amp = 16'd16056;
      4'd11:   amp = 16'd23789;
      4'd12:   amp = 16'd27360;
      4'd13:   amp = 16'd28900;
      4'd14:   amp = 16'd32718;
      default: amp = 16'd32767;
    endcase
    return amp;
  endfunction

endpackage

[src/psg_three_voice_sound_core.sv]
// Top level of the three-voice sound core: register file, tone, noise and
// envelope generators, and the channel mixer. Depends on psg_pkg.
//
// Each input item is a bus access (latch address, write, read) or one tick of
// the sound-chip clock, and gives exactly one result: the read data (zero for
// anything but a read) and the signed sum of the voice amplitudes after the
// item. One item is taken every cycle while input ready is high. The register
// file, dividers, noise shift register and envelope state all update at the
// edge that accepts the item; the read data is captured into a one-entry
// stage there, and when the stage moves on, the mix is formed from the updated
// state into the output register beside the read data. The stage and the
// output register together let the core keep accepting while a result waits
// to be taken; input ready drops only when both are full. The mix is the plain
// sum of the voice amplitudes, not divided by the voice count. Registers
// 7, 14 and 15 reset to all ones, everything else to zero; the noise shift
// register resets to one.
module psg_three_voice_sound_core
  import psg_pkg::*;
#(
  parameter int unsigned NUM_VOICES = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic [7:0]              bus_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              read_data_o,
  output logic signed [MIX_W-1:0] mix_sample_o
);

  // Register file and address latch
  logic [7:0]  regs_q [NUM_REGS];
  logic [3:0]  addr_q;

  // Tone generators
  logic [11:0]           tone_cnt_q [NUM_VOICES];
  logic [11:0]           tone_cnt_d [NUM_VOICES];
  logic [NUM_VOICES-1:0] tone_lvl_q, tone_lvl_d;

  // Noise generator
  logic [4:0]  noise_cnt_q, noise_cnt_d;
  logic [16:0] noise_sr_q, noise_sr_d;
  logic        noise_lvl_q, noise_lvl_d;

  // Envelope generator
  logic [15:0] env_cnt_q, env_cnt_d;
  logic [3:0]  env_phase_q, env_phase_d;
  logic        env_rise_q, env_rise_d;
  logic        env_frozen_q, env_frozen_d;
  logic [3:0]  env_lvl_q, env_lvl_d;

  // Result stage and output register
  logic                    s1_valid_q;
  logic [7:0]              s1_rd_q;
  logic                    out_valid_q;
  logic [7:0]              out_rd_q;
  logic signed [MIX_W-1:0] out_mix_q;

  logic    accept, move, do_tick, do_write, env_restart;
  action_e act;
  logic [7:0] rd_now;

  assign act         = action_e'(action_i);
  assign move        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || move;
  assign accept      = in_valid_i && in_ready_o;
  assign do_tick     = accept && (act == ACT_TICK);
  assign do_write    = accept && (act == ACT_WRITE);
  assign env_restart = do_write && (addr_q == REG_ENV_SHAPE);
  assign rd_now      = (act == ACT_READ) ? regs_q[addr_q] : 8'd0;

  // ---------------------------------------------------------------------------
  // Tone dividers: count+1 is compared one bit wider, so a period lowered
  // below the count fires on the next tick. Period zero behaves as one.
  // ---------------------------------------------------------------------------
  for (genvar v = 0; v < NUM_VOICES; v++) begin : g_tone
    logic [11:0] per;
    logic [11:0] per_eff;
    logic [12:0] cnt_inc;
    logic        fire;

    assign per     = {regs_q[2*v+1][3:0], regs_q[2*v]};
    assign per_eff = (per == 12'd0) ? 12'd1 : per;
    assign cnt_inc = {1'b0, tone_cnt_q[v]} + 13'd1;
    assign fire    = cnt_inc >= {1'b0, per_eff};

    always_comb begin
      tone_cnt_d[v] = tone_cnt_q[v];
      tone_lvl_d[v] = tone_lvl_q[v];
      if (do_tick) begin
        if (fire) begin
          tone_cnt_d[v] = 12'd0;
          tone_lvl_d[v] = !tone_lvl_q[v];
        end else begin
          tone_cnt_d[v] = cnt_inc[11:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Noise divider and 17-bit LFSR, taps at bits 0 and 2
  // ---------------------------------------------------------------------------
  logic [4:0]  noise_per_eff;
  logic [5:0]  noise_inc;
  logic [16:0] noise_sr_next;

  assign noise_per_eff = (regs_q[REG_NOISE_PER][4:0] == 5'd0) ? 5'd1
                                                              : regs_q[REG_NOISE_PER][4:0];
  assign noise_inc     = {1'b0, noise_cnt_q} + 6'd1;
  assign noise_sr_next = {noise_sr_q[0] ^ noise_sr_q[2], noise_sr_q[16:1]};

  always_comb begin
    noise_cnt_d = noise_cnt_q;
    noise_sr_d  = noise_sr_q;
    noise_lvl_d = noise_lvl_q;
    if (do_tick) begin
      if (noise_inc >= {1'b0, noise_per_eff}) begin
        noise_cnt_d = 5'd0;
        noise_sr_d  = noise_sr_next;
        noise_lvl_d = noise_sr_next[0];
      end else begin
        noise_cnt_d = noise_inc[4:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Envelope divider and shape machine. Shape bits: 3 continue, 2 attack,
  // 1 alternate, 0 hold. A write to the shape register restarts it.
  // ---------------------------------------------------------------------------
  logic [15:0] env_per, env_per_eff;
  logic [16:0] env_inc;
  logic [3:0]  shape;
  logic [4:0]  step_inc;
  logic        next_rise;

  assign env_per     = {regs_q[REG_ENV_COARSE], regs_q[REG_ENV_FINE]};
  assign env_per_eff = (env_per == 16'd0) ? 16'd1 : env_per;
  assign env_inc     = {1'b0, env_cnt_q} + 17'd1;
  assign shape       = regs_q[REG_ENV_SHAPE][3:0];
  assign step_inc    = {1'b0, env_phase_q} + 5'd1;
  assign next_rise   = shape[1] ? !env_rise_q : env_rise_q;

  always_comb begin
    env_cnt_d    = env_cnt_q;
    env_phase_d  = env_phase_q;
    env_rise_d   = env_rise_q;
    env_frozen_d = env_frozen_q;
    env_lvl_d    = env_lvl_q;
    if (env_restart) begin
      env_cnt_d    = 16'd0;
      env_phase_d  = 4'd0;
      env_rise_d   = bus_data_i[2];
      env_frozen_d = 1'b0;
      env_lvl_d    = bus_data_i[2] ? 4'd0 : 4'd15;
    end else if (do_tick) begin
      if (env_inc >= {1'b0, env_per_eff}) begin
        env_cnt_d = 16'd0;
        if (!env_frozen_q) begin
          if (step_inc[4]) begin
            // End of a sixteen-step phase
            env_phase_d = 4'd0;
            if (!shape[3]) begin
              env_lvl_d    = 4'd0;
              env_frozen_d = 1'b1;
            end else if (shape[0]) begin
              env_lvl_d    = next_rise ? 4'd15 : 4'd0;
              env_frozen_d = 1'b1;
            end else begin
              env_rise_d = next_rise;
              env_lvl_d  = next_rise ? 4'd0 : 4'd15;
            end
          end else begin
            env_phase_d = step_inc[3:0];
            env_lvl_d   = env_rise_q ? step_inc[3:0] : 4'd15 - step_inc[3:0];
          end
        end
      end else begin
        env_cnt_d = env_inc[15:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Mixer: a voice is high when its tone and noise paths are each high or
  // disabled; it adds +A when high and -A otherwise.
  // ---------------------------------------------------------------------------
  logic signed [MIX_W-1:0] mix_sum;

  always_comb begin
    logic [7:0]              amp_reg;
    logic [AMP_W-1:0]        amp;
    logic signed [MIX_W-1:0] amp_s;
    logic                    high;
    mix_sum = '0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      high    = (tone_lvl_q[v] || regs_q[REG_MIXER][v])
                && (noise_lvl_q || regs_q[REG_MIXER][v+3]);
      amp_reg = regs_q[REG_AMP_BASE + 4'(v)];
      amp     = vol_q15(amp_reg[4] ? env_lvl_q : amp_reg[3:0]);
      amp_s   = signed'({{(MIX_W-AMP_W){1'b0}}, amp});
      mix_sum = high ? mix_sum + amp_s : mix_sum - amp_s;
    end
  end

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= ((4'(i) == REG_MIXER) || (4'(i) == REG_PORT_A) ||
                      (4'(i) == REG_PORT_B)) ? 8'hFF : 8'h00;
      end
      addr_q <= 4'd0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        tone_cnt_q[v] <= 12'd0;
      end
      tone_lvl_q   <= '0;
      noise_cnt_q  <= 5'd0;
      noise_sr_q   <= 17'd1;
      noise_lvl_q  <= 1'b0;
      env_cnt_q    <= 16'd0;
      env_phase_q  <= 4'd0;
      env_rise_q   <= 1'b0;
      env_frozen_q <= 1'b0;
      env_lvl_q    <= 4'd0;
    end else begin
      if (accept && (act == ACT_LATCH)) begin
        addr_q <= bus_data_i[3:0];
      end
      if (do_write) begin
        regs_q[addr_q] <= bus_data_i;
      end
      for (int v = 0; v < NUM_VOICES; v++) begin
        tone_cnt_q[v] <= tone_cnt_d[v];
      end
      tone_lvl_q   <= tone_lvl_d;
      noise_cnt_q  <= noise_cnt_d;
      noise_sr_q   <= noise_sr_d;
      noise_lvl_q  <= noise_lvl_d;
      env_cnt_q    <= env_cnt_d;
      env_phase_q  <= env_phase_d;
      env_rise_q   <= env_rise_d;
      env_frozen_q <= env_frozen_d;
      env_lvl_q    <= env_lvl_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: hold the read data until the mix of the updated state
  // moves into the output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (move) begin
        s1_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q <= rd_now;
    end
    if (move) begin
      out_rd_q  <= s1_rd_q;
      out_mix_q <= mix_sum;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_rd_q;
  assign mix_sample_o = out_mix_q;

endmodule

[src/psg_checker.sv]
// Port-level checks for the three-voice sound core, bound to its top level.
// Depends on psg_pkg and psg_three_voice_sound_core.
module psg_checker
  import psg_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [7:0]              read_data_o,
  input logic signed [MIX_W-1:0] mix_sample_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
                                    && $stable(mix_sample_o))
    else $error("result changed while stalled");

  // With the output register empty the core never refuses an item
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with output register empty");

  // Every accepted item is followed by a result at the output
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("no result after accepted item");

  // The mix never leaves the three-voice range
  a_mix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mix_sample_o >= -18'sd98301) && (mix_sample_o <= 18'sd98301))
    else $error("mix sample out of range");

endmodule

bind psg_three_voice_sound_core psg_checker u_psg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .read_data_o  (read_data_o),
  .mix_sample_o (mix_sample_o)
);
